// ----- sv/triangle_area_interpolator_defines.svh -----
// ----------------------------------------------------------------------------
// triangle_area_interpolator_defines
// Assertion macros used by the top-level interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_AREA_INTERPOLATOR_DEFINES_SVH
`define TRIANGLE_AREA_INTERPOLATOR_DEFINES_SVH

// ante implies cons, checked on every rising edge out of reset
`define TAI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("interpolator check failed");

// cond must never be seen out of reset
`define TAI_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("interpolator forbidden condition");

`endif

// ----- sv/tai_pkg.sv -----
// ----------------------------------------------------------------------------
// tai_pkg
// Shared constants and latency helpers for the triangle interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tai_pkg;

    // width of one partial-product slice in the sliced multipliers
    localparam int MUL_CHUNK = 16;

    // number of slices needed to cover w bits
    function automatic int chunks(input int w);
        return (w + MUL_CHUNK - 1) / MUL_CHUNK;
    endfunction

    // register stages of the area unit for coordinate width n
    function automatic int area_latency(input int n);
        return 3 + (n + 1) + 3 + chunks(2 * (n + 3)) + 2 * (n + 3);
    endfunction

endpackage

// ----- sv/tai_area.sv -----
// ----------------------------------------------------------------------------
// tai_area
// Pipelined four-times-area unit: whole triangle plus the three sub-triangles
// around the query point, by Heron's stable form on floor-rooted sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tai_area
    import tai_pkg::*;
#(
    parameter int N = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [N-1:0]           v0_x,
    input  logic signed [N-1:0]           v0_y,
    input  logic signed [N-1:0]           v1_x,
    input  logic signed [N-1:0]           v1_y,
    input  logic signed [N-1:0]           v2_x,
    input  logic signed [N-1:0]           v2_y,
    input  logic signed [N-1:0]           query_x,
    input  logic signed [N-1:0]           query_y,
    input  logic [3*N-1:0]                side_in,
    output logic                          out_valid,
    output logic [3:0][2*(N+3)*2/2-1:0]   area,
    output logic [3*N-1:0]                side_out
);

    localparam int SW    = N + 1;          // side root bits
    localparam int SR    = 2 * SW;         // side radicand bits
    localparam int FW    = N + 3;          // Heron factor bits
    localparam int PW    = 2 * FW;         // pair product bits
    localparam int HW    = 2 * PW;         // Heron product bits
    localparam int AW    = PW;             // area root bits
    localparam int PK    = chunks(PW);     // slices of the second factor
    localparam int LAT_A = area_latency(N);

    // lane 0: whole triangle; lanes 1..3: sub-triangle opposite vertex 0..2
    logic signed [N-1:0] px [4][3];
    logic signed [N-1:0] py [4][3];

    always_comb
    begin
        px[0][0] = v0_x;    py[0][0] = v0_y;
        px[0][1] = v1_x;    py[0][1] = v1_y;
        px[0][2] = v2_x;    py[0][2] = v2_y;
        px[1][0] = v1_x;    py[1][0] = v1_y;
        px[1][1] = v2_x;    py[1][1] = v2_y;
        px[1][2] = query_x; py[1][2] = query_y;
        px[2][0] = v0_x;    py[2][0] = v0_y;
        px[2][1] = v2_x;    py[2][1] = v2_y;
        px[2][2] = query_x; py[2][2] = query_y;
        px[3][0] = v0_x;    py[3][0] = v0_y;
        px[3][1] = v1_x;    py[3][1] = v1_y;
        px[3][2] = query_x; py[3][2] = query_y;
    end

    logic [N-1:0]    dx_reg   [4][3];
    logic [N-1:0]    dy_reg   [4][3];
    logic [2*N-1:0]  sqx_reg  [4][3];
    logic [2*N-1:0]  sqy_reg  [4][3];
    logic [SR-1:0]   rad_reg  [4][3];
    logic [SR-1:0]   srad_reg [4][3][SW];
    logic [SW+1:0]   srem_reg [4][3][SW];
    logic [SW-1:0]   sroot_reg[4][3][SW];

    logic [SW-1:0]   sa_reg   [4];
    logic [SW-1:0]   sb_reg   [4];
    logic [SW-1:0]   sc_reg   [4];
    logic            sz_reg   [4];
    logic [FW-1:0]   f1_reg   [4];
    logic [FW-1:0]   f2_reg   [4];
    logic [FW-1:0]   f3_reg   [4];
    logic [FW-1:0]   f4_reg   [4];
    logic [PW-1:0]   p12_reg  [4];
    logic [PW-1:0]   p34_reg  [4];
    logic [HW-1:0]   hacc_reg [4][PK];
    logic [PW-1:0]   ha_reg   [4][PK];
    logic [PK*MUL_CHUNK-1:0] hb_reg [4][PK];
    logic [HW-1:0]   prad_reg [4][AW];
    logic [AW+1:0]   prem_reg [4][AW];
    logic [AW-1:0]   proot_reg[4][AW];

    genvar l, k, j;
    generate
        for (l = 0; l < 4; l++)
        begin : g_lane
            for (k = 0; k < 3; k++)
            begin : g_side
                localparam int KB = (k + 1) % 3;
                logic signed [N:0] ddx;
                logic signed [N:0] ddy;
                logic [N:0]        mdx;
                logic [N:0]        mdy;

                // coordinate differences and their magnitudes
                assign ddx = $signed({px[l][k][N-1], px[l][k]})
                           - $signed({px[l][KB][N-1], px[l][KB]});
                assign ddy = $signed({py[l][k][N-1], py[l][k]})
                           - $signed({py[l][KB][N-1], py[l][KB]});
                assign mdx = ddx[N] ? (N+1)'(-ddx) : (N+1)'(ddx);
                assign mdy = ddy[N] ? (N+1)'(-ddy) : (N+1)'(ddy);

                always_ff @(posedge clk)
                begin
                    dx_reg[l][k]  <= mdx[N-1:0];
                    dy_reg[l][k]  <= mdy[N-1:0];
                    sqx_reg[l][k] <= dx_reg[l][k] * dx_reg[l][k];
                    sqy_reg[l][k] <= dy_reg[l][k] * dy_reg[l][k];
                    rad_reg[l][k] <= SR'(sqx_reg[l][k]) + SR'(sqy_reg[l][k]);
                end

                // side root, one result bit per stage
                for (j = 0; j < SW; j++)
                begin : g_sroot
                    logic [SR-1:0] rad_i;
                    logic [SW+1:0] rem_i;
                    logic [SW-1:0] root_i;
                    logic [SW+3:0] shf;
                    logic [SW+3:0] trl;
                    logic [SW+3:0] dif;
                    logic          ge;

                    if (j == 0)
                    begin : g_first
                        assign rad_i  = rad_reg[l][k];
                        assign rem_i  = '0;
                        assign root_i = '0;
                    end
                    else
                    begin : g_next
                        assign rad_i  = srad_reg[l][k][j-1];
                        assign rem_i  = srem_reg[l][k][j-1];
                        assign root_i = sroot_reg[l][k][j-1];
                    end

                    assign shf = {rem_i, rad_i[SR-1 -: 2]};
                    assign trl = {2'b00, root_i, 2'b01};
                    assign dif = shf - trl;
                    assign ge  = (shf >= trl);

                    always_ff @(posedge clk)
                    begin
                        srem_reg[l][k][j]  <= ge ? dif[SW+1:0] : shf[SW+1:0];
                        sroot_reg[l][k][j] <= {root_i[SW-2:0], ge};
                        srad_reg[l][k][j]  <= {rad_i[SR-3:0], 2'b00};
                    end
                end
            end

            // sort sides a <= b <= c, flag a broken triangle inequality
            logic [SW-1:0] sa;
            logic [SW-1:0] sb;
            logic [SW-1:0] sc;
            logic [SW-1:0] st;

            always_comb
            begin
                st = '0;
                sa = sroot_reg[l][0][SW-1];
                sb = sroot_reg[l][1][SW-1];
                sc = sroot_reg[l][2][SW-1];
                if (sa > sb)
                begin
                    st = sa; sa = sb; sb = st;
                end
                if (sb > sc)
                begin
                    st = sb; sb = sc; sc = st;
                end
                if (sa > sb)
                begin
                    st = sa; sa = sb; sb = st;
                end
            end

            always_ff @(posedge clk)
            begin
                sa_reg[l] <= sa;
                sb_reg[l] <= sb;
                sc_reg[l] <= sc;
                sz_reg[l] <= ((SW+1)'(sa) + (SW+1)'(sb)) <= (SW+1)'(sc);
            end

            // Heron factors, zeroed when the triangle inequality is broken
            always_ff @(posedge clk)
            begin
                if (sz_reg[l])
                begin
                    f1_reg[l] <= '0;
                    f2_reg[l] <= '0;
                    f3_reg[l] <= '0;
                    f4_reg[l] <= '0;
                end
                else
                begin
                    f1_reg[l] <= FW'(sa_reg[l]) + FW'(sb_reg[l]) + FW'(sc_reg[l]);
                    f2_reg[l] <= FW'(sc_reg[l]) + FW'(sb_reg[l]) - FW'(sa_reg[l]);
                    f3_reg[l] <= FW'(sc_reg[l]) + FW'(sa_reg[l]) - FW'(sb_reg[l]);
                    f4_reg[l] <= FW'(sa_reg[l]) + FW'(sb_reg[l]) - FW'(sc_reg[l]);
                end
                p12_reg[l] <= f1_reg[l] * f2_reg[l];
                p34_reg[l] <= f3_reg[l] * f4_reg[l];
            end

            // wide product, one slice of the second factor per stage
            for (j = 0; j < PK; j++)
            begin : g_hmul
                logic [HW-1:0]             acc_i;
                logic [PW-1:0]             a_i;
                logic [PK*MUL_CHUNK-1:0]   b_i;
                logic [PW+MUL_CHUNK-1:0]   pp;

                if (j == 0)
                begin : g_first
                    assign acc_i = '0;
                    assign a_i   = p12_reg[l];
                    assign b_i   = (PK*MUL_CHUNK)'(p34_reg[l]);
                end
                else
                begin : g_next
                    assign acc_i = hacc_reg[l][j-1];
                    assign a_i   = ha_reg[l][j-1];
                    assign b_i   = hb_reg[l][j-1];
                end

                assign pp = a_i * b_i[j*MUL_CHUNK +: MUL_CHUNK];

                always_ff @(posedge clk)
                begin
                    hacc_reg[l][j] <= acc_i + (HW'(pp) << (j * MUL_CHUNK));
                    ha_reg[l][j]   <= a_i;
                    hb_reg[l][j]   <= b_i;
                end
            end

            // area root, one result bit per stage
            for (j = 0; j < AW; j++)
            begin : g_proot
                logic [HW-1:0] rad_i;
                logic [AW+1:0] rem_i;
                logic [AW-1:0] root_i;
                logic [AW+3:0] shf;
                logic [AW+3:0] trl;
                logic [AW+3:0] dif;
                logic          ge;

                if (j == 0)
                begin : g_first
                    assign rad_i  = hacc_reg[l][PK-1];
                    assign rem_i  = '0;
                    assign root_i = '0;
                end
                else
                begin : g_next
                    assign rad_i  = prad_reg[l][j-1];
                    assign rem_i  = prem_reg[l][j-1];
                    assign root_i = proot_reg[l][j-1];
                end

                assign shf = {rem_i, rad_i[HW-1 -: 2]};
                assign trl = {2'b00, root_i, 2'b01};
                assign dif = shf - trl;
                assign ge  = (shf >= trl);

                always_ff @(posedge clk)
                begin
                    prem_reg[l][j]  <= ge ? dif[AW+1:0] : shf[AW+1:0];
                    proot_reg[l][j] <= {root_i[AW-2:0], ge};
                    prad_reg[l][j]  <= {rad_i[HW-3:0], 2'b00};
                end
            end

            assign area[l] = proot_reg[l][AW-1];
        end
    endgenerate

    // valid and height sideband ride a shift line of matching length
    logic            vline_reg [LAT_A];
    logic [3*N-1:0]  zline_reg [LAT_A];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT_A; i++)
            begin
                vline_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vline_reg[0] <= in_valid;
            for (int i = 1; i < LAT_A; i++)
            begin
                vline_reg[i] <= vline_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        zline_reg[0] <= side_in;
        for (int i = 1; i < LAT_A; i++)
        begin
            zline_reg[i] <= zline_reg[i-1];
        end
    end

    assign out_valid = vline_reg[LAT_A-1];
    assign side_out  = zline_reg[LAT_A-1];

endmodule

// ----- sv/triangle_area_interpolator.sv -----
// ----------------------------------------------------------------------------
// triangle_area_interpolator
// Height at a query point from three triangle vertices, weighted by
// Heron sub-triangle areas and one exact floor division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the vertex and query fields and pulse start. busy
//   is held low, so a transaction is taken on every cycle start is high,
//   one per clock sustained.
//   Output channel: done is high for exactly one cycle with interp_z and
//   degenerate; results leave in input order and must be taken that cycle.
//   Pipeline: the area unit, the weighting slices, the sum and magnitude
//   registers, the one-bit-per-stage divider over the weighted sum of
//   MW = 3N+9 bits, and the output register. The divider chain and
//   the root chains inside the area unit set the depth.
//   Reset (rst_n low, asynchronous) clears every valid bit; transactions in
//   flight are dropped and no done is raised until new ones arrive.
//   The receiver has no stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_area_interpolator_defines.svh"

module triangle_area_interpolator
    import tai_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] v0_x,
    input  logic signed [COORD_BITS-1:0] v0_y,
    input  logic signed [COORD_BITS-1:0] v0_z,
    input  logic signed [COORD_BITS-1:0] v1_x,
    input  logic signed [COORD_BITS-1:0] v1_y,
    input  logic signed [COORD_BITS-1:0] v1_z,
    input  logic signed [COORD_BITS-1:0] v2_x,
    input  logic signed [COORD_BITS-1:0] v2_y,
    input  logic signed [COORD_BITS-1:0] v2_z,
    input  logic signed [COORD_BITS-1:0] query_x,
    input  logic signed [COORD_BITS-1:0] query_y,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] interp_z,
    output logic                         degenerate
);

    localparam int N   = COORD_BITS;
    localparam int AW  = 2 * (N + 3);         // area bits
    localparam int TW  = AW + N;              // weighted term bits
    localparam int SMW = TW + 2;              // sum of three terms
    localparam int MW  = SMW + 1;             // dividend bits
    localparam int ZK  = chunks(N);
    localparam int LAT = area_latency(N) + ZK + MW + 3;
    localparam logic [MW-1:0] HALF_W = MW'(1) << (N - 1);

    logic                  a_valid;
    logic [3:0][AW-1:0]    a_area;
    logic [3*N-1:0]        a_z;

    assign busy = 1'b0;

    tai_area #(
        .N (N)
    ) u_area (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .v0_x      (v0_x),
        .v0_y      (v0_y),
        .v1_x      (v1_x),
        .v1_y      (v1_y),
        .v2_x      (v2_x),
        .v2_y      (v2_y),
        .query_x   (query_x),
        .query_y   (query_y),
        .side_in   ({v2_z, v1_z, v0_z}),
        .out_valid (a_valid),
        .area      (a_area),
        .side_out  (a_z)
    );

    // weighting stages: area times |z|, one slice of |z| per stage
    logic [TW-1:0]          wacc_reg [3][ZK];
    logic [AW-1:0]          wt_reg   [3][ZK];
    logic [ZK*MUL_CHUNK-1:0] wz_reg  [3][ZK];
    logic                   wneg_reg [3][ZK];
    logic [AW-1:0]          wtat_reg [ZK];
    logic                   wv_reg   [ZK];

    genvar i, c;
    generate
        for (i = 0; i < 3; i++)
        begin : g_wlane
            logic signed [N-1:0] zs;
            logic [N-1:0]        zm;

            assign zs = a_z[i*N +: N];
            assign zm = zs[N-1] ? (~zs + 1'b1) : zs;

            for (c = 0; c < ZK; c++)
            begin : g_wmul
                logic [TW-1:0]            acc_i;
                logic [AW-1:0]            t_i;
                logic [ZK*MUL_CHUNK-1:0]  z_i;
                logic                     n_i;
                logic [AW+MUL_CHUNK-1:0]  pp;

                if (c == 0)
                begin : g_first
                    assign acc_i = '0;
                    assign t_i   = a_area[i+1];
                    assign z_i   = (ZK*MUL_CHUNK)'(zm);
                    assign n_i   = zs[N-1];
                end
                else
                begin : g_next
                    assign acc_i = wacc_reg[i][c-1];
                    assign t_i   = wt_reg[i][c-1];
                    assign z_i   = wz_reg[i][c-1];
                    assign n_i   = wneg_reg[i][c-1];
                end

                assign pp = t_i * z_i[c*MUL_CHUNK +: MUL_CHUNK];

                always_ff @(posedge clk)
                begin
                    wacc_reg[i][c] <= acc_i + (TW'(pp) << (c * MUL_CHUNK));
                    wt_reg[i][c]   <= t_i;
                    wz_reg[i][c]   <= z_i;
                    wneg_reg[i][c] <= n_i;
                end
            end
        end

        // whole-area and valid travel with the weighting slices
        for (c = 0; c < ZK; c++)
        begin : g_wside
            always_ff @(posedge clk)
            begin
                wtat_reg[c] <= (c == 0) ? a_area[0] : wtat_reg[(c == 0) ? 0 : c-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    wv_reg[c] <= 1'b0;
                end
                else
                begin
                    wv_reg[c] <= (c == 0) ? a_valid : wv_reg[(c == 0) ? 0 : c-1];
                end
            end
        end
    endgenerate

    // split terms by sign of z and sum each side
    logic [SMW-1:0] pos_next;
    logic [SMW-1:0] neg_next;
    logic [SMW-1:0] pos_reg;
    logic [SMW-1:0] neg_reg;
    logic [AW-1:0]  stat_reg;
    logic           sv_reg;

    always_comb
    begin
        pos_next = '0;
        neg_next = '0;
        for (int n = 0; n < 3; n++)
        begin
            if (wneg_reg[n][ZK-1])
            begin
                neg_next = neg_next + SMW'(wacc_reg[n][ZK-1]);
            end
            else
            begin
                pos_next = pos_next + SMW'(wacc_reg[n][ZK-1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        stat_reg <= wtat_reg[ZK-1];
    end

    // signed magnitude of the dividend, biased for a floor on negatives
    logic [MW-1:0] mag_reg;
    logic          msgn_reg;
    logic [AW-1:0] mtat_reg;
    logic          mv_reg;

    always_ff @(posedge clk)
    begin
        if (pos_reg >= neg_reg)
        begin
            mag_reg  <= MW'(pos_reg) - MW'(neg_reg);
            msgn_reg <= 1'b0;
        end
        else
        begin
            mag_reg  <= MW'(neg_reg) - MW'(pos_reg) + MW'(stat_reg) - MW'(1);
            msgn_reg <= 1'b1;
        end
        mtat_reg <= stat_reg;
    end

    // restoring divider, one quotient bit per stage
    logic [AW-1:0] drem_reg [MW];
    logic [MW-1:0] dnum_reg [MW];
    logic [MW-1:0] dq_reg   [MW];
    logic [AW-1:0] dtat_reg [MW];
    logic          dsgn_reg [MW];
    logic          dv_reg   [MW];

    generate
        for (c = 0; c < MW; c++)
        begin : g_div
            logic [AW-1:0] rem_i;
            logic [MW-1:0] num_i;
            logic [MW-1:0] q_i;
            logic [AW-1:0] d_i;
            logic          s_i;
            logic [AW:0]   shf;
            logic [AW:0]   dif;
            logic          ge;

            if (c == 0)
            begin : g_first
                assign rem_i = '0;
                assign num_i = mag_reg;
                assign q_i   = '0;
                assign d_i   = mtat_reg;
                assign s_i   = msgn_reg;
            end
            else
            begin : g_next
                assign rem_i = drem_reg[c-1];
                assign num_i = dnum_reg[c-1];
                assign q_i   = dq_reg[c-1];
                assign d_i   = dtat_reg[c-1];
                assign s_i   = dsgn_reg[c-1];
            end

            assign shf = {rem_i, num_i[MW-1]};
            assign dif = shf - {1'b0, d_i};
            assign ge  = (shf >= {1'b0, d_i});

            always_ff @(posedge clk)
            begin
                drem_reg[c] <= ge ? dif[AW-1:0] : shf[AW-1:0];
                dnum_reg[c] <= {num_i[MW-2:0], 1'b0};
                dq_reg[c]   <= {q_i[MW-2:0], ge};
                dtat_reg[c] <= d_i;
                dsgn_reg[c] <= s_i;
            end
        end
    endgenerate

    // valid bits for the sum, magnitude and divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
            mv_reg <= 1'b0;
            for (int n = 0; n < MW; n++)
            begin
                dv_reg[n] <= 1'b0;
            end
        end
        else
        begin
            sv_reg    <= wv_reg[ZK-1];
            mv_reg    <= sv_reg;
            dv_reg[0] <= mv_reg;
            for (int n = 1; n < MW; n++)
            begin
                dv_reg[n] <= dv_reg[n-1];
            end
        end
    end

    // saturate, apply sign, force zero on a degenerate triangle
    logic [MW-1:0]         qf;
    logic signed [N-1:0]   z_next;
    logic                  deg_next;
    logic signed [N-1:0]   z_reg;
    logic                  deg_reg;
    logic                  done_reg;

    assign qf       = dq_reg[MW-1];
    assign deg_next = (dtat_reg[MW-1] == '0);

    always_comb
    begin
        if (deg_next)
        begin
            z_next = '0;
        end
        else if (!dsgn_reg[MW-1])
        begin
            z_next = (qf >= HALF_W) ? {1'b0, {(N-1){1'b1}}} : qf[N-1:0];
        end
        else
        begin
            z_next = (qf >= HALF_W) ? {1'b1, {(N-1){1'b0}}} : (~qf[N-1:0] + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg   <= z_next;
        deg_reg <= deg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[MW-1];
        end
    end

    assign done       = done_reg;
    assign interp_z   = z_reg;
    assign degenerate = deg_reg;

    // every accepted transaction returns a done, and every done traces back to an accepted start
    `TAI_ASSERT_IMPL(a_done_after_start, start && !busy, ##LAT done)
    `TAI_ASSERT_IMPL(a_start_before_done, done, $past(start && !busy, LAT))
    `TAI_ASSERT_NEVER(a_degen_nonzero, done && degenerate && (interp_z != '0))

endmodule

// ----- bench/tb_triangle_area_interpolator.sv -----
// ----------------------------------------------------------------------------
// tb_triangle_area_interpolator
// Self-checking bench for the triangle height interpolator: directed corner
// transactions, random triangles with bursty start, and a scoreboard that
// compares every done strobe against a software predictor of the Heron areas.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_area_interpolator;

    localparam int N        = 24;
    localparam int LATENCY  = 175;
    localparam int WD_LIMIT = 4000;
    localparam logic signed [N-1:0] ZMAX = {1'b0, {(N-1){1'b1}}};
    localparam logic signed [N-1:0] ZMIN = {1'b1, {(N-1){1'b0}}};

    typedef struct packed {
        logic signed [N-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy;
    } tri_query_t;

    typedef struct packed {
        logic signed [N-1:0] z;
        logic                degen;
    } height_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [N-1:0] v0_x = '0, v0_y = '0, v0_z = '0;
    logic signed [N-1:0] v1_x = '0, v1_y = '0, v1_z = '0;
    logic signed [N-1:0] v2_x = '0, v2_y = '0, v2_z = '0;
    logic signed [N-1:0] query_x = '0, query_y = '0;
    logic done;
    logic signed [N-1:0] interp_z;
    logic degenerate;

    height_t expected_heights[$];
    int      error_count = 0;
    int      idle_cycles = 0;

    triangle_area_interpolator #(.COORD_BITS(N)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
        .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
        .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
        .query_x(query_x), .query_y(query_y),
        .done(done), .interp_z(interp_z), .degenerate(degenerate)
    );

    always #4 clk = ~clk;

    // floor square root, bit by bit
    function automatic logic [159:0] isqrt(input logic [159:0] n);
        logic [159:0] root, bitv, t;
        root = '0;
        bitv = 160'd1 << 158;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            t = root + bitv;
            if (n >= t) begin
                n = n - t;
                root = (root >> 1) + bitv;
            end
            else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] side_len(input longint x0, y0, x1, y1);
        logic [159:0] dx, dy;
        dx = 160'((x0 > x1) ? x0 - x1 : x1 - x0);
        dy = 160'((y0 > y1) ? y0 - y1 : y1 - y0);
        return 64'(isqrt(dx * dx + dy * dy));
    endfunction

    // four times the triangle area, stable Heron form on sorted sides
    function automatic logic [159:0] area4(input longint x0, y0, x1, y1, x2, y2);
        logic [63:0]  a, b, c, t;
        logic [159:0] p;
        a = side_len(x0, y0, x1, y1);
        b = side_len(x1, y1, x2, y2);
        c = side_len(x2, y2, x0, y0);
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        if (a + b <= c) return '0;
        p = 160'(a + b + c) * 160'(c - a + b) * 160'(c + a - b) * 160'(a + b - c);
        return isqrt(p);
    endfunction

    function automatic height_t predict_height(input tri_query_t q);
        logic [159:0] whole, sub0, sub1, sub2, pos, neg, quo;
        height_t h;
        whole = area4(q.ax, q.ay, q.bx, q.by, q.cx, q.cy);
        sub0  = area4(q.bx, q.by, q.cx, q.cy, q.qx, q.qy);
        sub1  = area4(q.ax, q.ay, q.cx, q.cy, q.qx, q.qy);
        sub2  = area4(q.ax, q.ay, q.bx, q.by, q.qx, q.qy);
        h.degen = (whole == 0);
        h.z = '0;
        if (!h.degen) begin
            pos = '0;
            neg = '0;
            if (q.az < 0) neg += sub0 * 160'(-longint'(q.az)); else pos += sub0 * 160'(q.az);
            if (q.bz < 0) neg += sub1 * 160'(-longint'(q.bz)); else pos += sub1 * 160'(q.bz);
            if (q.cz < 0) neg += sub2 * 160'(-longint'(q.cz)); else pos += sub2 * 160'(q.cz);
            if (pos >= neg) begin
                quo = (pos - neg) / whole;
                h.z = (quo > 160'(ZMAX)) ? ZMAX : N'(quo);
            end
            else begin
                quo = (neg - pos + whole - 1) / whole;
                h.z = (quo >= (160'd1 << (N-1))) ? ZMIN : -N'(quo);
            end
        end
        return h;
    endfunction

    // send one transaction; waits for busy low
    task automatic send_query(input tri_query_t q);
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, query_x, query_y} = q;
        start = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_heights.insert(expected_heights.size(), predict_height(q));
        @(negedge clk);
    endtask

    task automatic pause_gap(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic signed [N-1:0] rnd_coord(input int span);
        case ($urandom_range(3))
            0: return N'($urandom);
            1: return N'($urandom_range(2 * span) - span);
            2: return ($urandom_range(1)) ? ZMAX - N'($urandom_range(span)) :
                                             ZMIN + N'($urandom_range(span));
            default: return N'($urandom_range(64) - 32);
        endcase
    endfunction

    function automatic tri_query_t rnd_query();
        tri_query_t q;
        int span;
        span = (1 << $urandom_range(20, 2));
        q = '{ax: rnd_coord(span), ay: rnd_coord(span), az: N'($urandom),
              bx: rnd_coord(span), by: rnd_coord(span), bz: N'($urandom),
              cx: rnd_coord(span), cy: rnd_coord(span), cz: N'($urandom),
              qx: rnd_coord(span), qy: rnd_coord(span)};
        // some queries lie on a vertex, some triangles collapse
        case ($urandom_range(9))
            0: begin q.qx = q.ax; q.qy = q.ay; end
            1: begin q.cx = q.bx; q.cy = q.by; end
            default: ;
        endcase
        return q;
    endfunction

    // corners: extremes, degenerate, inside/outside, saturation
    task automatic test_directed();
        tri_query_t q;
        q = '{ax: 0, ay: 0, az: 100, bx: 1000, by: 0, bz: 200,
              cx: 0, cy: 1000, cz: 300, qx: 250, qy: 250};
        send_query(q);
        q.qx = 5000; q.qy = -5000;                 // outside, extrapolates
        send_query(q);
        q.qx = 0; q.qy = 0;                        // on a vertex
        send_query(q);
        q.bx = 0; q.by = 0;                        // two vertices coincide
        send_query(q);
        q = '{ax: 0, ay: 0, az: 5, bx: 1, by: 1, bz: 5,
              cx: 2, cy: 2, cz: 5, qx: 1, qy: 0};  // collinear
        send_query(q);
        q = '{ax: 0, ay: 0, az: 9, bx: 1, by: 0, bz: 9,
              cx: 0, cy: 1, cz: 9, qx: 0, qy: 0};  // rounded sides all come out equal
        send_query(q);
        q = '{ax: ZMIN, ay: ZMIN, az: ZMAX, bx: ZMAX, by: ZMIN, bz: ZMAX,
              cx: ZMIN, cy: ZMAX, cz: ZMAX, qx: ZMAX, qy: ZMAX};
        send_query(q);                             // positive saturation
        q.az = ZMIN; q.bz = ZMIN; q.cz = ZMIN;
        send_query(q);                             // negative saturation
        q.qx = ZMIN; q.qy = ZMIN;
        send_query(q);
        q = '{ax: -7, ay: -3, az: -1, bx: 13, by: -2, bz: -2,
              cx: 4, cy: 11, cz: 1, qx: 3, qy: 2}; // floor of negative
        send_query(q);
        q = '{default: '1};
        send_query(q);
        q = '{default: '0};
        send_query(q);
        pause_gap(0);
    endtask

    // bursts of back-to-back transactions with random gaps
    task automatic test_random_bursts(input int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(40, 1);
            repeat (burst) begin
                send_query(rnd_query());
                count--;
            end
            if ($urandom_range(3) != 0) pause_gap($urandom_range(12));
        end
        pause_gap(0);
    endtask

    // sender holds off until the pipeline has drained
    task automatic test_drain_pause();
        pause_gap(1);
        while (expected_heights.size() != 0) @(negedge clk);
        repeat (3) send_query(rnd_query());
        pause_gap(0);
    endtask

    // scoreboard on every done strobe
    always @(posedge clk) begin
        height_t exp_h;
        if (rst_n && done) begin
            if (expected_heights.size() == 0) begin
                $display("%0t: unexpected result z=%0d degenerate=%0b",
                         $realtime, interp_z, degenerate);
                error_count++;
            end
            else begin
                exp_h = expected_heights.pop_front();
                if (interp_z !== exp_h.z) begin
                    $display("%0t: interp_z expected %0d actual %0d",
                             $realtime, exp_h.z, interp_z);
                    error_count++;
                end
                if (degenerate !== exp_h.degen) begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $realtime, exp_h.degen, degenerate);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction either way
    always @(posedge clk) begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("tb_triangle_area_interpolator: done, errors");
            $finish;
        end
    end

    initial begin
        int wait_cycles;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_bursts(250);
        test_drain_pause();
        test_random_bursts(250);
        wait_cycles = 0;
        while (expected_heights.size() != 0 && wait_cycles < WD_LIMIT) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (LATENCY) @(negedge clk);
        if (error_count == 0 && expected_heights.size() == 0)
            $display("tb_triangle_area_interpolator: done, clean");
        else
            $display("tb_triangle_area_interpolator: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tai_pkg.sv
sv/tai_area.sv
sv/triangle_area_interpolator.sv
bench/tb_triangle_area_interpolator.sv
